// ===== rtl/core/rmps_pkg.sv =====
// Shared types, widths, codes and the direction table of the ray march pixel stepper.
package rmps_pkg;

  // Number of evenly spaced ray angles; a power of two from 8 to 512
  localparam int RAY_COUNT = 512;
  localparam int RAY_BITS  = $clog2(RAY_COUNT);
  localparam int QUAD_BITS = RAY_BITS - 2;
  localparam int QUARTER   = RAY_COUNT / 4;

  // Field widths
  localparam int PIX_W   = 12;
  localparam int RAD_W   = 10;
  localparam int ANGLE_W = 9;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = 30;
  localparam int DIR_W   = 17;
  localparam int MAG_W   = 16;
  localparam int OFS_W   = POS_W + 1;
  localparam int SQ_W    = 61;
  localparam int RSQ_W   = 2 * (RAD_W + FRAC_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration reset values
  localparam logic [PIX_W-1:0] RST_OBSTACLE_X = PIX_W'(550);
  localparam logic [PIX_W-1:0] RST_OBSTACLE_Y = PIX_W'(300);
  localparam logic [RAD_W-1:0] RST_RADIUS     = RAD_W'(40);
  localparam logic [PIX_W-1:0] RST_SCREEN_W   = PIX_W'(1200);
  localparam logic [PIX_W-1:0] RST_SCREEN_H   = PIX_W'(600);

  // Fixed-point constants for the table build
  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSTACLE_X      = 3'd0,
    CFG_OBSTACLE_Y      = 3'd1,
    CFG_OBSTACLE_RADIUS = 3'd2,
    CFG_SCREEN_WIDTH    = 3'd3,
    CFG_SCREEN_HEIGHT   = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [MAG_W-1:0] sin_mag;
    logic [MAG_W-1:0] cos_mag;
  } dir_mag_t;

  typedef dir_mag_t [QUARTER-1:0] dir_rom_t;

  typedef struct packed {
    logic hit;
    logic off;
  } step_status_t;

  // Q31 product of two magnitudes
  function automatic logic [63:0] q31_mul(logic [63:0] t, logic [63:0] a);
    logic [63:0] p;
    p = t * a;
    return p >> 31;
  endfunction

  // Clamp and round half up from Q31 to a Q15 magnitude
  function automatic logic [MAG_W-1:0] to_q15(logic signed [63:0] v);
    logic signed [63:0] w;
    w = (v < 0) ? 64'sd0 : v;
    w = (w + 64'sd32768) >>> 16;
    if (w > 64'sd32768) w = 64'sd32768;
    return w[MAG_W-1:0];
  endfunction

  // Sine and cosine magnitudes of one angle within the first quadrant
  function automatic dir_mag_t dir_entry(int unsigned q);
    logic [63:0]        a;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    dir_mag_t           e;
    a  = (HALF_PI_Q31 * 64'(4 * q)) / 64'(RAY_COUNT);
    ts = a;
    tc = ONE_Q31;
    s  = $signed(a);
    c  = $signed(ONE_Q31);
    // term 1
    ts = q31_mul(ts, a) / 64'd2;  ts = q31_mul(ts, a) / 64'd3;
    tc = q31_mul(tc, a) / 64'd1;  tc = q31_mul(tc, a) / 64'd2;
    s = s - $signed(ts);  c = c - $signed(tc);
    // term 2
    ts = q31_mul(ts, a) / 64'd4;  ts = q31_mul(ts, a) / 64'd5;
    tc = q31_mul(tc, a) / 64'd3;  tc = q31_mul(tc, a) / 64'd4;
    s = s + $signed(ts);  c = c + $signed(tc);
    // term 3
    ts = q31_mul(ts, a) / 64'd6;  ts = q31_mul(ts, a) / 64'd7;
    tc = q31_mul(tc, a) / 64'd5;  tc = q31_mul(tc, a) / 64'd6;
    s = s - $signed(ts);  c = c - $signed(tc);
    // term 4
    ts = q31_mul(ts, a) / 64'd8;  ts = q31_mul(ts, a) / 64'd9;
    tc = q31_mul(tc, a) / 64'd7;  tc = q31_mul(tc, a) / 64'd8;
    s = s + $signed(ts);  c = c + $signed(tc);
    // term 5
    ts = q31_mul(ts, a) / 64'd10; ts = q31_mul(ts, a) / 64'd11;
    tc = q31_mul(tc, a) / 64'd9;  tc = q31_mul(tc, a) / 64'd10;
    s = s - $signed(ts);  c = c - $signed(tc);
    // term 6
    ts = q31_mul(ts, a) / 64'd12; ts = q31_mul(ts, a) / 64'd13;
    tc = q31_mul(tc, a) / 64'd11; tc = q31_mul(tc, a) / 64'd12;
    s = s + $signed(ts);  c = c + $signed(tc);
    // term 7
    ts = q31_mul(ts, a) / 64'd14; ts = q31_mul(ts, a) / 64'd15;
    tc = q31_mul(tc, a) / 64'd13; tc = q31_mul(tc, a) / 64'd14;
    s = s - $signed(ts);  c = c - $signed(tc);
    // term 8
    ts = q31_mul(ts, a) / 64'd16; ts = q31_mul(ts, a) / 64'd17;
    tc = q31_mul(tc, a) / 64'd15; tc = q31_mul(tc, a) / 64'd16;
    s = s + $signed(ts);  c = c + $signed(tc);
    // term 9
    ts = q31_mul(ts, a) / 64'd18; ts = q31_mul(ts, a) / 64'd19;
    tc = q31_mul(tc, a) / 64'd17; tc = q31_mul(tc, a) / 64'd18;
    s = s - $signed(ts);  c = c - $signed(tc);
    // term 10
    ts = q31_mul(ts, a) / 64'd20; ts = q31_mul(ts, a) / 64'd21;
    tc = q31_mul(tc, a) / 64'd19; tc = q31_mul(tc, a) / 64'd20;
    s = s + $signed(ts);  c = c + $signed(tc);
    e.sin_mag = to_q15(s);
    e.cos_mag = to_q15(c);
    return e;
  endfunction

  function automatic dir_rom_t build_dir_rom();
    dir_rom_t rom;
    for (int q = 0; q < QUARTER; q++) begin
      rom[q] = dir_entry(q);
    end
    return rom;
  endfunction

  // Quarter-wave direction table, built at elaboration
  localparam dir_rom_t DIR_ROM = build_dir_rom();

endpackage

// ===== rtl/core/rmps_in_if.sv =====
// Input channel of the ray march pixel stepper: handshake and command payload.
interface rmps_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [rmps_pkg::PIX_W-1:0]    start_x;
  logic [rmps_pkg::PIX_W-1:0]    start_y;
  logic [rmps_pkg::ANGLE_W-1:0]  angle_index;

  modport source (output valid, func, start_x, start_y, angle_index, input ready);
  modport sink   (input valid, func, start_x, start_y, angle_index, output ready);
endinterface

// ===== rtl/core/rmps_out_if.sv =====
// Result channel of the ray march pixel stepper: handshake and pixel report payload.
interface rmps_out_if;
  logic                        valid;
  logic                        ready;
  logic [rmps_pkg::PIX_W-1:0]  pixel_x;
  logic [rmps_pkg::PIX_W-1:0]  pixel_y;
  logic                        drawn;
  logic                        hit;
  logic                        done_res;

  modport source (output valid, pixel_x, pixel_y, drawn, hit, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, drawn, hit, done_res, output ready);
endinterface

// ===== rtl/core/rmps_dir_lookup.sv =====
// Direction lookup: quarter-wave cosine/sine table with quadrant folding.
module rmps_dir_lookup (
  input  logic [rmps_pkg::ANGLE_W-1:0]       angle_index,
  output logic signed [rmps_pkg::DIR_W-1:0]  dir_x,
  output logic signed [rmps_pkg::DIR_W-1:0]  dir_y
);

  logic [rmps_pkg::QUAD_BITS-1:0]     qidx;
  rmps_pkg::quad_t                    quad;
  rmps_pkg::dir_mag_t                 mag;
  logic signed [rmps_pkg::DIR_W-1:0]  sin_p;
  logic signed [rmps_pkg::DIR_W-1:0]  cos_p;

  // split the angle into quadrant and offset inside it
  assign qidx  = angle_index[rmps_pkg::QUAD_BITS-1:0];
  assign quad  = rmps_pkg::quad_t'(angle_index[rmps_pkg::RAY_BITS-1 -: 2]);
  assign mag   = rmps_pkg::DIR_ROM[qidx];
  assign sin_p = $signed({1'b0, mag.sin_mag});
  assign cos_p = $signed({1'b0, mag.cos_mag});

  // rotate the first-quadrant vector into place
  always_comb begin
    case (quad)
      rmps_pkg::QUAD_0: begin dir_x = cos_p;  dir_y = sin_p;  end
      rmps_pkg::QUAD_1: begin dir_x = -sin_p; dir_y = cos_p;  end
      rmps_pkg::QUAD_2: begin dir_x = -cos_p; dir_y = -sin_p; end
      rmps_pkg::QUAD_3: begin dir_x = sin_p;  dir_y = -cos_p; end
      default:          begin dir_x = cos_p;  dir_y = sin_p;  end
    endcase
  end

endmodule

// ===== rtl/core/rmps_step_test.sv =====
// Point test: obstacle circle distance compare and screen bounds check.
module rmps_step_test (
  input  logic signed [rmps_pkg::POS_W-1:0]  pos_x,
  input  logic signed [rmps_pkg::POS_W-1:0]  pos_y,
  input  logic signed [rmps_pkg::OFS_W-1:0]  ofs_x,
  input  logic signed [rmps_pkg::OFS_W-1:0]  ofs_y,
  input  logic [rmps_pkg::RAD_W-1:0]         radius,
  input  logic [rmps_pkg::PIX_W-1:0]         screen_w,
  input  logic [rmps_pkg::PIX_W-1:0]         screen_h,
  output rmps_pkg::step_status_t             status
);

  logic signed [2*rmps_pkg::OFS_W-1:0]            sq_x;
  logic signed [2*rmps_pkg::OFS_W-1:0]            sq_y;
  logic [rmps_pkg::SQ_W-1:0]                      dist_sq;
  logic [rmps_pkg::RAD_W+rmps_pkg::FRAC_W-1:0]    rad_q;
  logic [rmps_pkg::RSQ_W-1:0]                     rad_sq;
  logic                                           off_x;
  logic                                           off_y;

  // squared distance to the circle centre, exact in Q32
  assign sq_x    = ofs_x * ofs_x;
  assign sq_y    = ofs_y * ofs_y;
  assign dist_sq = rmps_pkg::SQ_W'($unsigned(sq_x)) + rmps_pkg::SQ_W'($unsigned(sq_y));
  assign rad_q   = {radius, {rmps_pkg::FRAC_W{1'b0}}};
  assign rad_sq  = rad_q * rad_q;

  // off screen when negative or at or past the edge
  assign off_x = pos_x[rmps_pkg::POS_W-1] ||
                 (pos_x[rmps_pkg::POS_W-2:rmps_pkg::FRAC_W] >= {1'b0, screen_w});
  assign off_y = pos_y[rmps_pkg::POS_W-1] ||
                 (pos_y[rmps_pkg::POS_W-2:rmps_pkg::FRAC_W] >= {1'b0, screen_h});

  assign status.hit = dist_sq <= rmps_pkg::SQ_W'(rad_sq);
  assign status.off = off_x || off_y;

endmodule

// ===== rtl/core/ray_march_pixel_stepper_core.sv =====
// Ray march pixel stepper top level: ray state, step pipeline and result register.
// A load beat places a ray at its start pixel with a table direction; a step beat
// moves it one unit and reports the pixel, an obstacle hit and whether the ray has
// ended. One beat is accepted every cycle unless the result stalls. The first stage
// holds the updated position and its offsets from the circle centre, the second
// the result after the circle and screen test. Ray activity is tracked at the
// result stage, so back-to-back steps see the outcome of the step before them.
// Configuration must be written only while idle; the block does not enforce it.
module ray_march_pixel_stepper_core (
  input  logic                               clk,
  input  logic                               rst_n,
  rmps_in_if.sink                            in_ch,
  rmps_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rmps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PAD_W = rmps_pkg::POS_W - rmps_pkg::PIX_W - rmps_pkg::FRAC_W;
  localparam int OPAD_W = rmps_pkg::OFS_W - rmps_pkg::PIX_W - rmps_pkg::FRAC_W;
  localparam int SPAD_W = rmps_pkg::POS_W - rmps_pkg::DIR_W - 1;

  // configuration registers
  logic [rmps_pkg::PIX_W-1:0]  obstacle_x_r;
  logic [rmps_pkg::PIX_W-1:0]  obstacle_y_r;
  logic [rmps_pkg::RAD_W-1:0]  radius_r;
  logic [rmps_pkg::PIX_W-1:0]  screen_w_r;
  logic [rmps_pkg::PIX_W-1:0]  screen_h_r;

  // first stage: ray position and offsets
  logic                                s1_vld_r,  s1_vld_nxt;
  logic                                s1_load_r, s1_load_nxt;
  logic signed [rmps_pkg::POS_W-1:0]   pos_x_r,   pos_x_nxt;
  logic signed [rmps_pkg::POS_W-1:0]   pos_y_r,   pos_y_nxt;
  logic signed [rmps_pkg::DIR_W-1:0]   dir_x_r,   dir_x_nxt;
  logic signed [rmps_pkg::DIR_W-1:0]   dir_y_r,   dir_y_nxt;
  logic signed [rmps_pkg::OFS_W-1:0]   ofs_x_r,   ofs_x_nxt;
  logic signed [rmps_pkg::OFS_W-1:0]   ofs_y_r,   ofs_y_nxt;

  // result stage
  logic                        active_r,   active_nxt;
  logic                        out_vld_r,  out_vld_nxt;
  logic [rmps_pkg::PIX_W-1:0]  pixel_x_r,  pixel_x_nxt;
  logic [rmps_pkg::PIX_W-1:0]  pixel_y_r,  pixel_y_nxt;
  logic                        drawn_r,    drawn_nxt;
  logic                        hit_r,      hit_nxt;
  logic                        done_r,     done_nxt;

  logic                               out_take;
  logic                               in_rdy;
  logic                               accept;
  logic                               advance;
  logic signed [rmps_pkg::DIR_W-1:0]  lut_dir_x;
  logic signed [rmps_pkg::DIR_W-1:0]  lut_dir_y;
  rmps_pkg::step_status_t             status;

  // handshake: result register frees when empty or taken
  assign out_take = !out_vld_r || out_ch.ready;
  assign in_rdy   = !s1_vld_r || out_take;
  assign accept   = in_ch.valid && in_rdy;
  assign advance  = s1_vld_r && out_take;

  assign in_ch.ready     = in_rdy;
  assign out_ch.valid    = out_vld_r;
  assign out_ch.pixel_x  = pixel_x_r;
  assign out_ch.pixel_y  = pixel_y_r;
  assign out_ch.drawn    = drawn_r;
  assign out_ch.hit      = hit_r;
  assign out_ch.done_res = done_r;

  rmps_dir_lookup u_dir_lookup (
    .angle_index (in_ch.angle_index),
    .dir_x       (lut_dir_x),
    .dir_y       (lut_dir_y)
  );

  rmps_step_test u_step_test (
    .pos_x    (pos_x_r),
    .pos_y    (pos_y_r),
    .ofs_x    (ofs_x_r),
    .ofs_y    (ofs_y_r),
    .radius   (radius_r),
    .screen_w (screen_w_r),
    .screen_h (screen_h_r),
    .status   (status)
  );

  // write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_x_r <= rmps_pkg::RST_OBSTACLE_X;
      obstacle_y_r <= rmps_pkg::RST_OBSTACLE_Y;
      radius_r     <= rmps_pkg::RST_RADIUS;
      screen_w_r   <= rmps_pkg::RST_SCREEN_W;
      screen_h_r   <= rmps_pkg::RST_SCREEN_H;
    end else if (cfg_we) begin
      case (cfg_index)
        rmps_pkg::CFG_OBSTACLE_X:      obstacle_x_r <= cfg_wdata[rmps_pkg::PIX_W-1:0];
        rmps_pkg::CFG_OBSTACLE_Y:      obstacle_y_r <= cfg_wdata[rmps_pkg::PIX_W-1:0];
        rmps_pkg::CFG_OBSTACLE_RADIUS: radius_r     <= cfg_wdata[rmps_pkg::RAD_W-1:0];
        rmps_pkg::CFG_SCREEN_WIDTH:    screen_w_r   <= cfg_wdata[rmps_pkg::PIX_W-1:0];
        rmps_pkg::CFG_SCREEN_HEIGHT:   screen_h_r   <= cfg_wdata[rmps_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // load or advance the ray on an accepted beat; offsets follow the new position
  always_comb begin
    s1_load_nxt = s1_load_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    dir_x_nxt   = dir_x_r;
    dir_y_nxt   = dir_y_r;
    if (accept) begin
      if (in_ch.func == rmps_pkg::FUNC_LOAD) begin
        s1_load_nxt = 1'b1;
        pos_x_nxt   = $signed({{PAD_W{1'b0}}, in_ch.start_x, {rmps_pkg::FRAC_W{1'b0}}});
        pos_y_nxt   = $signed({{PAD_W{1'b0}}, in_ch.start_y, {rmps_pkg::FRAC_W{1'b0}}});
        dir_x_nxt   = lut_dir_x;
        dir_y_nxt   = lut_dir_y;
      end else begin
        s1_load_nxt = 1'b0;
        pos_x_nxt   = pos_x_r + $signed({{SPAD_W{dir_x_r[rmps_pkg::DIR_W-1]}}, dir_x_r, 1'b0});
        pos_y_nxt   = pos_y_r + $signed({{SPAD_W{dir_y_r[rmps_pkg::DIR_W-1]}}, dir_y_r, 1'b0});
      end
    end
    ofs_x_nxt = $signed({pos_x_nxt[rmps_pkg::POS_W-1], pos_x_nxt}) -
                $signed({{OPAD_W{1'b0}}, obstacle_x_r, {rmps_pkg::FRAC_W{1'b0}}});
    ofs_y_nxt = $signed({pos_y_nxt[rmps_pkg::POS_W-1], pos_y_nxt}) -
                $signed({{OPAD_W{1'b0}}, obstacle_y_r, {rmps_pkg::FRAC_W{1'b0}}});
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (out_take) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  // form the result beat and update ray activity
  always_comb begin
    active_nxt  = active_r;
    out_vld_nxt = out_vld_r;
    pixel_x_nxt = pixel_x_r;
    pixel_y_nxt = pixel_y_r;
    drawn_nxt   = drawn_r;
    hit_nxt     = hit_r;
    done_nxt    = done_r;
    if (out_take) begin
      out_vld_nxt = s1_vld_r;
    end
    if (advance) begin
      pixel_x_nxt = '0;
      pixel_y_nxt = '0;
      drawn_nxt   = 1'b0;
      hit_nxt     = 1'b0;
      done_nxt    = 1'b0;
      if (s1_load_r) begin
        active_nxt = 1'b1;
      end else if (!active_r) begin
        done_nxt = 1'b1;
      end else begin
        hit_nxt  = status.hit;
        done_nxt = status.hit || status.off;
        if (!status.off) begin
          pixel_x_nxt = pos_x_r[rmps_pkg::FRAC_W +: rmps_pkg::PIX_W];
          pixel_y_nxt = pos_y_r[rmps_pkg::FRAC_W +: rmps_pkg::PIX_W];
          drawn_nxt   = 1'b1;
        end
        active_nxt = !(status.hit || status.off);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      active_r  <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      active_r  <= active_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_load_r <= s1_load_nxt;
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    dir_x_r   <= dir_x_nxt;
    dir_y_r   <= dir_y_nxt;
    ofs_x_r   <= ofs_x_nxt;
    ofs_y_r   <= ofs_y_nxt;
    pixel_x_r <= pixel_x_nxt;
    pixel_y_r <= pixel_y_nxt;
    drawn_r   <= drawn_nxt;
    hit_r     <= hit_nxt;
    done_r    <= done_nxt;
  end

endmodule

// ===== tb/ray_pixel_checker.sv =====
// Checker for the ray march pixel stepper: predicts every pixel report and compares it.
module ray_pixel_checker
  import rmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rmps_in_if                    in_mon,
  rmps_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Quarter turn and unity in Q31, for the Taylor expansion of the direction table
  localparam logic [63:0] QTR_TURN_Q31 = 64'd3373259426;
  localparam logic [63:0] UNIT_Q31     = 64'd2147483648;
  localparam int          TAYLOR_TERMS = 10;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             drawn;
    logic             hit;
    logic             done_res;
  } pixel_report_t;

  // Ray state and register shadows
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic signed [DIR_W-1:0] dir_x, dir_y;
  logic                    ray_live;
  logic [PIX_W-1:0]        obs_x, obs_y, scr_w, scr_h;
  logic [RAD_W-1:0]        obs_r;

  logic signed [DIR_W-1:0] cos_tab [RAY_COUNT];
  logic signed [DIR_W-1:0] sin_tab [RAY_COUNT];
  pixel_report_t           reports_due [$];
  int                      mismatches = 0;

  // Clamp a Q31 sum to [0, 1.0] and round half up to Q15
  function automatic longint round_to_q15(longint v);
    longint w;
    w = (v < 0) ? 0 : v;
    w = (w + 32768) >>> 16;
    if (w > 32768) w = 32768;
    return w;
  endfunction

  // Unit vector for one angle slot: first-quadrant series, then quadrant signs
  function automatic void unit_dir(input int unsigned idx,
                                   output logic signed [DIR_W-1:0] cx,
                                   output logic signed [DIR_W-1:0] sy);
    logic [63:0] k, qsel, rem, a, ts, tc;
    longint      s, c, sm, cm;
    quad_t       quad;
    k    = 64'(4 * (idx % RAY_COUNT));
    qsel = k / 64'(RAY_COUNT);
    quad = quad_t'(qsel[1:0]);
    rem  = k % 64'(RAY_COUNT);
    a    = (QTR_TURN_Q31 * rem) / 64'(RAY_COUNT);
    ts   = a;
    tc   = UNIT_Q31;
    s    = longint'(a);
    c    = longint'(UNIT_Q31);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      ts = ((ts * a) >> 31) / 64'(2 * n);
      ts = ((ts * a) >> 31) / 64'(2 * n + 1);
      tc = ((tc * a) >> 31) / 64'(2 * n - 1);
      tc = ((tc * a) >> 31) / 64'(2 * n);
      if (n % 2 == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    sm = round_to_q15(s);
    cm = round_to_q15(c);
    case (quad)
      QUAD_0: begin cx = DIR_W'(cm);  sy = DIR_W'(sm);  end
      QUAD_1: begin cx = DIR_W'(-sm); sy = DIR_W'(cm);  end
      QUAD_2: begin cx = DIR_W'(-cm); sy = DIR_W'(-sm); end
      default: begin cx = DIR_W'(sm); sy = DIR_W'(-cm); end
    endcase
  endfunction

  // Apply one command beat to the ray state and return the report it causes
  function automatic pixel_report_t march_step(input logic             fbit,
                                               input logic [PIX_W-1:0] sx,
                                               input logic [PIX_W-1:0] sy,
                                               input logic [ANGLE_W-1:0] ang);
    pixel_report_t rep;
    longint        nx, ny, dx, dy, rr;
    logic          hit_now, off_now;
    int unsigned   slot;
    rep = '0;
    if (func_t'(fbit) == FUNC_LOAD) begin
      pos_x    = {2'b00, sx, {FRAC_W{1'b0}}};
      pos_y    = {2'b00, sy, {FRAC_W{1'b0}}};
      slot     = ang % RAY_COUNT;
      dir_x    = cos_tab[slot];
      dir_y    = sin_tab[slot];
      ray_live = 1'b1;
      return rep;
    end
    if (!ray_live) begin
      rep.done_res = 1'b1;
      return rep;
    end
    // Advance one pixel, wrapping within the position width
    nx    = longint'(pos_x) + 2 * longint'(dir_x);
    ny    = longint'(pos_y) + 2 * longint'(dir_y);
    pos_x = nx[POS_W-1:0];
    pos_y = ny[POS_W-1:0];
    // Circle test, exact in Q32
    dx      = longint'(pos_x) - (longint'(obs_x) << FRAC_W);
    dy      = longint'(pos_y) - (longint'(obs_y) << FRAC_W);
    rr      = longint'(obs_r) << FRAC_W;
    hit_now = (dx * dx + dy * dy) <= rr * rr;
    off_now = pos_x < 0 || longint'(pos_x) >= (longint'(scr_w) << FRAC_W) ||
              pos_y < 0 || longint'(pos_y) >= (longint'(scr_h) << FRAC_W);
    if (!off_now) begin
      rep.px    = pos_x[PIX_W+FRAC_W-1:FRAC_W];
      rep.py    = pos_y[PIX_W+FRAC_W-1:FRAC_W];
      rep.drawn = 1'b1;
    end
    rep.hit = hit_now;
    if (hit_now || off_now) begin
      rep.done_res = 1'b1;
      ray_live     = 1'b0;
    end
    return rep;
  endfunction

  function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    for (int i = 0; i < RAY_COUNT; i++) unit_dir(i, cos_tab[i], sin_tab[i]);
  end

  always @(posedge clk) begin : watch
    pixel_report_t seen, want;
    if (!rst_n) begin
      pos_x    = '0;
      pos_y    = '0;
      dir_x    = '0;
      dir_y    = '0;
      ray_live = 1'b0;
      obs_x    = PIX_W'(550);
      obs_y    = PIX_W'(300);
      obs_r    = RAD_W'(40);
      scr_w    = PIX_W'(1200);
      scr_h    = PIX_W'(600);
      reports_due.delete();
    end else begin
      // Retire a result beat against the oldest prediction
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        seen = '{out_mon.pixel_x, out_mon.pixel_y, out_mon.drawn, out_mon.hit,
                 out_mon.done_res};
        if (reports_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got x=%0d y=%0d drawn=%b hit=%b done=%b",
                   $time, seen.px, seen.py, seen.drawn, seen.hit, seen.done_res);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("pixel_x", want.px, seen.px);
          check_field("pixel_y", want.py, seen.py);
          check_field("drawn", want.drawn, seen.drawn);
          check_field("hit", want.hit, seen.hit);
          check_field("done_res", want.done_res, seen.done_res);
        end
      end
      // Predict the report of an accepted command beat
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        reports_due.push_back(march_step(in_mon.func, in_mon.start_x, in_mon.start_y,
                                         in_mon.angle_index));
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OBSTACLE_X:      obs_x = cfg_wdata[PIX_W-1:0];
          CFG_OBSTACLE_Y:      obs_y = cfg_wdata[PIX_W-1:0];
          CFG_OBSTACLE_RADIUS: obs_r = cfg_wdata[RAD_W-1:0];
          CFG_SCREEN_WIDTH:    scr_w = cfg_wdata[PIX_W-1:0];
          CFG_SCREEN_HEIGHT:   scr_h = cfg_wdata[PIX_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count = mismatches;
    pending    = reports_due.size();
  end

endmodule

// ===== tb/ray_march_pixel_stepper_core_tb.sv =====
// Testbench top of the ray march pixel stepper: command stimulus, back-pressure and verdict.
module ray_march_pixel_stepper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmps_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    send_run = 0;
  int                    recv_run = 0;
  int                    cur_ox, cur_oy, cur_r, cur_w, cur_h;

  rmps_in_if  in_ch ();
  rmps_out_if out_ch ();

  ray_march_pixel_stepper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ray_pixel_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle cycles before a beat; now and then a run of back-to-back beats
  function automatic int pick_wait(ref int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      run_left = $urandom_range(15, 50);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Near the obstacle, near a screen edge, or anywhere
  function automatic int pick_coord(int centre, int reach, int edge_at);
    int v;
    case ($urandom_range(0, 2))
      0: v = centre - reach + int'($urandom_range(0, 2 * reach));
      1: v = ($urandom_range(0, 1) == 1) ? edge_at - 1 - int'($urandom_range(0, 6))
                                         : int'($urandom_range(0, 6));
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Present one command beat and hold it until taken
  task automatic send_beat(func_t f, int sx, int sy, int ang);
    int gap;
    gap = pick_wait(send_run);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.start_x     <= PIX_W'(sx);
    in_ch.start_y     <= PIX_W'(sy);
    in_ch.angle_index <= ANGLE_W'(ang);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and wait until every report has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_cfg(int ox, int oy, int r, int w, int h);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OBSTACLE_X;
    cfg_wdata <= CFG_DATA_W'(ox);
    @(negedge clk);
    cfg_index <= CFG_OBSTACLE_Y;
    cfg_wdata <= CFG_DATA_W'(oy);
    @(negedge clk);
    // Upper data bits above the radius width are don't-care; toggle them
    cfg_index <= CFG_OBSTACLE_RADIUS;
    cfg_wdata <= CFG_DATA_W'(r) | (CFG_DATA_W'($urandom_range(0, 3)) << RAD_W);
    @(negedge clk);
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_ox = ox;
    cur_oy = oy;
    cur_r  = r;
    cur_w  = w;
    cur_h  = h;
  endtask

  // Mostly full rays (load then a run of steps), with some random noise beats
  task automatic run_rays(int items);
    int sent, steps, ang;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_beat(func_t'($urandom_range(0, 1)), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 511));
        sent++;
      end else begin
        ang = ($urandom_range(0, 3) == 0) ? 64 * $urandom_range(0, 7)
                                          : $urandom_range(0, 511);
        send_beat(FUNC_LOAD, pick_coord(cur_ox, cur_r + 6, cur_w),
                  pick_coord(cur_oy, cur_r + 6, cur_h), ang);
        steps = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
        repeat (steps) send_beat(FUNC_STEP, $urandom_range(0, 4095),
                                 $urandom_range(0, 4095), $urandom_range(0, 511));
        sent += steps + 1;
      end
    end
  endtask

  // Result side: random stall before each beat
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = pick_wait(recv_run);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      @(negedge clk);
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_LOAD;
    in_ch.start_x     = '0;
    in_ch.start_y     = '0;
    in_ch.angle_index = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_OBSTACLE_X;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    cur_ox = 550;
    cur_oy = 300;
    cur_r  = 40;
    cur_w  = 1200;
    cur_h  = 600;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: step with no ray, off-screen exits on each edge, a hit, extreme fields
    send_beat(FUNC_STEP, 4095, 4095, 511);
    send_beat(FUNC_LOAD, 0, 0, 256);
    send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_LOAD, 4095, 4095, 511);
    send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_LOAD, 505, 300, 0);
    repeat (6) send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_LOAD, 1199, 599, 0);
    send_beat(FUNC_STEP, 4095, 4095, 511);
    send_beat(FUNC_LOAD, 10, 20, 128);
    send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_LOAD, 300, 0, 384);
    send_beat(FUNC_STEP, 0, 0, 0);
    send_beat(FUNC_LOAD, 300, 599, 128);
    send_beat(FUNC_STEP, 0, 0, 0);
    run_rays(40);

    // Random rays over a range of obstacle and screen settings
    program_cfg(16, 16, 6, 40, 32);
    run_rays(80);
    program_cfg(0, 0, 1023, 4095, 4095);
    run_rays(80);
    program_cfg(4095, 4095, 0, 4095, 4095);
    run_rays(80);
    program_cfg(20, 10, 3, 1, 1);
    run_rays(60);
    program_cfg(10, 10, 5, 0, 0);
    run_rays(60);
    repeat (3) begin
      program_cfg($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 24),
                  $urandom_range(1, 64), $urandom_range(1, 64));
      run_rays(80);
    end
    program_cfg(550, 300, 40, 1200, 600);
    run_rays(60);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== ray_march_pixel_stepper_core.f =====
rtl/core/rmps_pkg.sv
rtl/core/rmps_in_if.sv
rtl/core/rmps_out_if.sv
rtl/core/rmps_dir_lookup.sv
rtl/core/rmps_step_test.sv
rtl/core/ray_march_pixel_stepper_core.sv
tb/ray_pixel_checker.sv
tb/ray_march_pixel_stepper_core_tb.sv
